### rtl/kts_pkg.sv
`default_nettype none
package kts_pkg;

  localparam int unsigned ValW = 32;

  typedef enum logic [0:0] {
    OpAdd    = 1'b0,
    OpSample = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SShift,
    SScan,
    SDiv,
    SMul,
    SDone
  } state_e;

  // One keyframe as held by a cell.
  typedef struct packed {
    logic [ValW-1:0] t;
    logic [ValW-1:0] x;
    logic [ValW-1:0] y;
    logic [ValW-1:0] z;
  } key_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic insert;   // cells holding a later key, or at or past count, load from left or new key
    logic scan;     // rotate the row one place toward cell 0
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/keyframe_track_sampler.sv
`default_nettype none
// Sequence: an add is inserted in the setup step, then its status is returned.
// An interpolated sample takes the setup step, the scan (one full rotation of the
// cell row plus a decision step), the divider and the multiply steps; end-key
// samples skip the divider and multiply. Throughput: one word at a time; next
// word accepted the cycle after the result is taken.
// Reset: count and control clear asynchronously; key storage is not reset.
module keyframe_track_sampler #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        operation_i,
  input  logic [31:0] time_req_i,
  input  logic [31:0] key_x_i,
  input  logic [31:0] key_y_i,
  input  logic [31:0] key_z_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic [1:0]  status_o,
  output logic [4:0]  stored_count_o
);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  kts_pkg::state_e state_q, state_d;

  // Captured word.
  logic               op_q;
  kts_pkg::key_t      req_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    step_q, step_d;   // scan position (rotations done)

  // Cell row.
  kts_pkg::cell_ctl_t ctl;
  kts_pkg::key_t      keys [DEPTH];
  logic [DEPTH-1:0]   used;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign used[g] = (CntW'(g) < count_q);
      kts_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (ctl),
        .used_i     (used[g]),
        .left_used_i((g == 0) ? 1'b0 : used[(g == 0) ? 0 : g - 1]),
        .new_key_i  (req_q),
        .left_key_i (keys[(g == 0) ? 0 : g - 1]),
        .right_key_i(keys[(g + 1) % DEPTH]),
        .key_o      (keys[g])
      );
    end
  endgenerate

  // Scan bookkeeping: cell 0 shows the key at index step_q.
  kts_pkg::key_t k0_q, prev_q, lo_q, hi_q;   // first key, previous key, bracket
  logic          mode_first_q, mode_first_d;  // at or below first key
  logic          mode_last_q, mode_last_d;    // at or above last key

  // Divider and multiply.
  logic        div_start, div_done;
  logic [16:0] quo;
  logic [16:0] frac_q;
  logic signed [63:0] px_q, py_q, pz_q;
  logic [31:0] rx_q, ry_q, rz_q;
  logic [1:0]  st_q;

  logic [31:0] num, den;
  assign num = 32'(req_q.t - lo_q.t);
  assign den = 32'(hi_q.t - lo_q.t);

  kts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  logic accept;
  assign ready_o = (state_q == kts_pkg::SIdle);
  assign accept  = valid_i && ready_o;

  // Next state. The scan always runs DEPTH rotations so the row returns to
  // order; the decision is taken at step DEPTH, when the row does not rotate.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kts_pkg::SIdle: if (accept) state_d = kts_pkg::SShift;
      kts_pkg::SShift: begin
        if (op_q == kts_pkg::OpAdd || count_q == '0) state_d = kts_pkg::SDone;
        else state_d = kts_pkg::SScan;
      end
      kts_pkg::SScan: begin
        if (step_q == CntW'(DEPTH)) begin
          state_d = (mode_first_q || mode_last_q) ? kts_pkg::SDone : kts_pkg::SDiv;
        end
      end
      kts_pkg::SDiv: if (div_done) state_d = kts_pkg::SMul;
      kts_pkg::SMul: if (step_q == CntW'(2)) state_d = kts_pkg::SDone;
      kts_pkg::SDone: if (ready_i) state_d = kts_pkg::SIdle;
      default: state_d = kts_pkg::SIdle;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctl.insert = 1'b0;
    ctl.scan   = 1'b0;
    div_start  = 1'b0;
    if (state_q == kts_pkg::SShift && op_q == kts_pkg::OpAdd && count_q != CntW'(DEPTH)) begin
      ctl.insert = 1'b1;
    end
    if (state_q == kts_pkg::SScan && step_q != CntW'(DEPTH)) begin
      // rotate all DEPTH cells so the row returns to order after DEPTH steps
      ctl.scan = 1'b1;
    end
    if (state_q == kts_pkg::SScan && step_q == CntW'(DEPTH) &&
        !mode_first_q && !mode_last_q) begin
      div_start = 1'b1;
    end
  end

  kts_pkg::key_t cur;
  assign cur = keys[0];

  always_comb begin
    count_d      = count_q;
    step_d       = step_q;
    mode_first_d = mode_first_q;
    mode_last_d  = mode_last_q;
    if (accept) step_d = '0;
    if (ctl.insert) count_d = count_q + CntW'(1);
    if (state_q == kts_pkg::SShift) begin
      mode_first_d = 1'b0;
      mode_last_d  = 1'b0;
    end
    if (state_q == kts_pkg::SScan && step_q != CntW'(DEPTH)) begin
      step_d = step_q + CntW'(1);
      if (step_q == '0) begin
        mode_first_d = $signed(req_q.t) <= $signed(cur.t);
      end
      if (step_q == count_q - CntW'(1)) begin
        mode_last_d = $signed(req_q.t) >= $signed(cur.t) && !mode_first_d;
      end
    end
    if (state_q == kts_pkg::SDiv && div_done) step_d = '0;
    if (state_q == kts_pkg::SMul) step_d = step_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kts_pkg::SIdle;
      count_q      <= '0;
      step_q       <= '0;
      mode_first_q <= 1'b0;
      mode_last_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      step_q       <= step_d;
      mode_first_q <= mode_first_d;
      mode_last_q  <= mode_last_d;
    end
  end

  logic signed [32:0] dx, dy, dz;
  assign dx = $signed({hi_q.x[31], hi_q.x}) - $signed({lo_q.x[31], lo_q.x});
  assign dy = $signed({hi_q.y[31], hi_q.y}) - $signed({lo_q.y[31], lo_q.y});
  assign dz = $signed({hi_q.z[31], hi_q.z}) - $signed({lo_q.z[31], lo_q.z});

  function automatic logic [31:0] lerp_fin(input logic [31:0] a, input logic signed [63:0] p);
    logic signed [63:0] q;
    begin
      q = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
      lerp_fin = 32'($signed(a) + q);
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      req_q  <= '{t: time_req_i, x: key_x_i, y: key_y_i, z: key_z_i};
    end
    // Track the bracket while the stored keys pass cell 0. Keys are sorted,
    // so exactly one adjacent pair straddles an in-range sample time.
    if (state_q == kts_pkg::SScan && step_q < count_q) begin
      if (step_q == '0) begin
        k0_q <= cur;
      end else if ($signed(prev_q.t) <= $signed(req_q.t) &&
                   $signed(req_q.t) < $signed(cur.t)) begin
        lo_q <= prev_q;
        hi_q <= cur;
      end
      prev_q <= cur;
    end
    if (div_done) frac_q <= quo;
    if (state_q == kts_pkg::SMul && step_q == '0) begin
      px_q <= 64'(dx * $signed({1'b0, frac_q[15:0]}));
      py_q <= 64'(dy * $signed({1'b0, frac_q[15:0]}));
      pz_q <= 64'(dz * $signed({1'b0, frac_q[15:0]}));
    end
    // Result register.
    if (state_q == kts_pkg::SShift) begin
      rx_q <= '0; ry_q <= '0; rz_q <= '0;
      if (op_q == kts_pkg::OpAdd) begin
        st_q <= (count_q == CntW'(DEPTH)) ? kts_pkg::StFull : kts_pkg::StOk;
      end else begin
        st_q <= (count_q == '0) ? kts_pkg::StEmpty : kts_pkg::StOk;
      end
    end
    // prev_q holds the last stored key once the scan is through.
    if (state_q == kts_pkg::SScan && step_q == CntW'(DEPTH)) begin
      if (mode_first_q) begin
        rx_q <= k0_q.x; ry_q <= k0_q.y; rz_q <= k0_q.z;
      end else if (mode_last_q) begin
        rx_q <= prev_q.x; ry_q <= prev_q.y; rz_q <= prev_q.z;
      end
    end
    if (state_q == kts_pkg::SMul && step_q == CntW'(1)) begin
      rx_q <= lerp_fin(lo_q.x, px_q);
      ry_q <= lerp_fin(lo_q.y, py_q);
      rz_q <= lerp_fin(lo_q.z, pz_q);
    end
  end

  assign valid_o        = (state_q == kts_pkg::SDone);
  assign out_x_o        = rx_q;
  assign out_y_o        = ry_q;
  assign out_z_o        = rz_q;
  assign status_o       = st_q;
  assign stored_count_o = 5'(count_q);

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH)) else $error("count overflow");
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !ready_o) else $error("ready while result pending");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CntW'(1)))
    else $error("count jumped");
`endif
endmodule
`default_nettype wire

### rtl/kts_cell.sv
`default_nettype none
// One keyframe slot. On insert: a slot holding a key later than the new time
// moves right; the first such slot (or the first free slot) takes the new key.
// On scan the row rotates toward cell 0 so the sequencer sees every key.
module kts_cell (
  input  logic             clk_i,
  input  kts_pkg::cell_ctl_t ctl_i,
  input  logic             used_i,       // this slot holds a key
  input  logic             left_used_i,
  input  kts_pkg::key_t    new_key_i,
  input  kts_pkg::key_t    left_key_i,   // neighbor at index - 1
  input  kts_pkg::key_t    right_key_i,  // neighbor at index + 1 (rotation)
  output kts_pkg::key_t    key_o
);
  kts_pkg::key_t key_q, key_d;
  logic left_gt, self_gt;

  assign left_gt = left_used_i && ($signed(left_key_i.t) > $signed(new_key_i.t));
  assign self_gt = used_i && ($signed(key_q.t) > $signed(new_key_i.t));

  always_comb begin
    key_d = key_q;
    if (ctl_i.insert) begin
      if (left_gt) begin
        key_d = left_key_i;
      end else if (self_gt || !used_i) begin
        key_d = new_key_i;
      end
    end else if (ctl_i.scan) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
endmodule
`default_nettype wire

### rtl/kts_div.sv
`default_nettype none
// Restoring divider: 16-bit quotient of (num << 16) / den, num < den, one bit a cycle.
module kts_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [16:0] quo_o
);
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic [16:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] sh;

  assign sh = {rem_q, 1'b0};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quo_d  = '0;
      cnt_d  = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {2'b00, den_q}) begin
        rem_d = 33'(sh - {2'b00, den_q});
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = sh[32:0];
        quo_d = {quo_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = busy_q && (cnt_q == 5'd1);
  assign quo_o  = quo_d;
endmodule
`default_nettype wire
